@@ rtl/core/kvst_pkg.sv @@
// Shared types, token codes and header constants for the snapshot tokenizer.
package kvst_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam logic [3:0] KIND_HEADER_OK    = 4'd0;
    localparam logic [3:0] KIND_HEADER_BAD   = 4'd1;
    localparam logic [3:0] KIND_DB_INDEX     = 4'd2;
    localparam logic [3:0] KIND_TABLE_SIZE   = 4'd3;
    localparam logic [3:0] KIND_EXPIRY_SIZE  = 4'd4;
    localparam logic [3:0] KIND_EXPIRY_MS    = 4'd5;
    localparam logic [3:0] KIND_EXPIRY_S     = 4'd6;
    localparam logic [3:0] KIND_STR_LEN      = 4'd7;
    localparam logic [3:0] KIND_STR_BYTE     = 4'd8;
    localparam logic [3:0] KIND_INT_STRING   = 4'd9;
    localparam logic [3:0] KIND_END          = 4'd10;
    localparam logic [3:0] KIND_BAD_TYPE     = 4'd11;
    localparam logic [3:0] KIND_BAD_ENCODING = 4'd12;

    localparam logic [7:0] OP_METADATA  = 8'hFA;
    localparam logic [7:0] OP_SELECT_DB = 8'hFE;
    localparam logic [7:0] OP_TABLE_SZ  = 8'hFB;
    localparam logic [7:0] OP_EXPIRY_MS = 8'hFC;
    localparam logic [7:0] OP_EXPIRY_S  = 8'hFD;
    localparam logic [7:0] OP_END       = 8'hFF;
    localparam logic [7:0] ENC_INT_MAX  = 8'hC2;
    localparam logic [7:0] TYPE_STRING  = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic [1:0]  string_role;
        logic        last_byte;
    } t_out_word;

    typedef struct packed {
        logic     vld;
        t_in_word word;
    } t_in_stage;

    typedef struct packed {
        logic      vld;
        t_out_word word;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] m;
        unique case (idx)
            3'd0:    m = 8'h52;
            3'd1:    m = 8'h45;
            3'd2:    m = 8'h44;
            3'd3:    m = 8'h49;
            3'd4:    m = 8'h53;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/kvst_in_reg.sv @@
// Input register: holds one accepted word until the parser takes it.
module kvst_in_reg import kvst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    output logic      o_stall,
    input  logic      i_advance,
    output t_in_stage o_stage
);

    logic     r_vld;
    logic     n_vld;
    t_in_word r_word;
    logic     load;

    assign o_stall = r_vld & ~i_advance;
    assign load    = i_valid & ~o_stall;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (load) begin
            r_word <= i_word;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.word = r_word;

endmodule

@@ rtl/core/kvst_parser.sv @@
// Parser state and single-pass decode of one file byte into at most one token.
module kvst_parser import kvst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_word  i_word,
    output t_result   o_result
);

    typedef enum logic [3:0] {
        PH_HDR, PH_TOP, PH_DEAD, PH_EXP, PH_VTYPE, PH_STRB, PH_SZ0, PH_SZC, PH_INT
    } t_phase;

    localparam logic [1:0] PUR_DB     = 2'd0;
    localparam logic [1:0] PUR_TSIZE  = 2'd1;
    localparam logic [1:0] PUR_ESIZE  = 2'd2;
    localparam logic [1:0] PUR_STRLEN = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = '1;

    t_phase                 r_phase, n_phase, c_phase;
    logic [3:0]             r_pos, n_pos, c_pos;
    logic                   r_match, n_match, c_match;
    logic [63:0]            r_acc, n_acc, c_acc;
    logic [31:0]            r_sleft, n_sleft, c_sleft;
    logic [COUNT_WIDTH-1:0] r_eleft, n_eleft, c_eleft;
    logic [1:0]             r_role, n_role, c_role;
    logic                   r_secs, n_secs, c_secs;
    logic [1:0]             r_pur, n_pur;
    logic [1:0]             r_ilen, n_ilen;

    logic [7:0]  b;
    logic [3:0]  pos_inc;
    logic        do_fin;
    logic [63:0] fin_v;
    logic        do_vtype;
    logic        do_sdone;
    logic [31:0] sleft_dec;
    logic [2:0]  ipos_inc;
    logic [2:0]  ineed;
    logic [63:0] ival;
    t_result     res;

    always_comb begin
        b        = i_word.data_byte;
        c_phase  = i_word.start_of_file ? PH_HDR : r_phase;
        c_pos    = i_word.start_of_file ? 4'd0 : r_pos;
        c_match  = i_word.start_of_file ? 1'b1 : r_match;
        c_acc    = i_word.start_of_file ? 64'd0 : r_acc;
        c_sleft  = i_word.start_of_file ? 32'd0 : r_sleft;
        c_eleft  = i_word.start_of_file ? '0 : r_eleft;
        c_role   = i_word.start_of_file ? 2'd0 : r_role;
        c_secs   = i_word.start_of_file ? 1'b0 : r_secs;

        n_phase  = c_phase;
        n_pos    = c_pos;
        n_match  = c_match;
        n_acc    = c_acc;
        n_sleft  = c_sleft;
        n_eleft  = c_eleft;
        n_role   = c_role;
        n_secs   = c_secs;
        n_pur    = r_pur;
        n_ilen   = r_ilen;

        pos_inc   = c_pos + 4'd1;
        ipos_inc  = {1'b0, c_pos[1:0]} + 3'd1;
        ineed     = 3'd1 << r_ilen;
        sleft_dec = c_sleft - 32'd1;
        ival      = 64'd0;
        do_fin    = 1'b0;
        fin_v     = 64'd0;
        do_vtype  = 1'b0;
        do_sdone  = 1'b0;
        res       = '0;

        unique case (c_phase)
            PH_HDR: begin
                if (c_pos < 4'd5 && b != magic_byte(c_pos[2:0])) begin
                    n_match = 1'b0;
                end
                n_pos = pos_inc;
                if (pos_inc >= 4'd9) begin
                    res.vld              = 1'b1;
                    res.word.token_kind  = n_match ? KIND_HEADER_OK : KIND_HEADER_BAD;
                    n_phase              = n_match ? PH_TOP : PH_DEAD;
                    n_pos                = 4'd0;
                end
            end
            PH_TOP: begin
                if (c_eleft != '0) begin
                    n_eleft = c_eleft - 1'b1;
                    if (b == OP_EXPIRY_MS || b == OP_EXPIRY_S) begin
                        n_secs  = (b == OP_EXPIRY_S);
                        n_acc   = 64'd0;
                        n_pos   = 4'd0;
                        n_phase = PH_EXP;
                    end else begin
                        do_vtype = 1'b1;
                    end
                end else begin
                    case (b)
                        OP_METADATA: begin
                            n_role  = 2'd0;
                            n_pur   = PUR_STRLEN;
                            n_phase = PH_SZ0;
                        end
                        OP_SELECT_DB: begin
                            n_pur   = PUR_DB;
                            n_phase = PH_SZ0;
                        end
                        OP_TABLE_SZ: begin
                            n_pur   = PUR_TSIZE;
                            n_phase = PH_SZ0;
                        end
                        OP_END: begin
                            res.vld             = 1'b1;
                            res.word.token_kind = KIND_END;
                            n_phase             = PH_DEAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_EXP: begin
                for (int i = 0; i < 8; i++) begin
                    if (c_pos[2:0] == 3'(i)) begin
                        n_acc[8*i +: 8] = c_acc[8*i +: 8] | b;
                    end
                end
                n_pos = {1'b0, c_pos[2:0]} + 4'd1;
                if (n_pos >= (c_secs ? 4'd4 : 4'd8)) begin
                    res.vld              = 1'b1;
                    res.word.token_kind  = c_secs ? KIND_EXPIRY_S : KIND_EXPIRY_MS;
                    res.word.token_value = n_acc;
                    n_phase              = PH_VTYPE;
                end
            end
            PH_VTYPE: begin
                do_vtype = 1'b1;
            end
            PH_STRB: begin
                res.vld              = 1'b1;
                res.word.token_kind  = KIND_STR_BYTE;
                res.word.token_value = {56'd0, b};
                res.word.string_role = c_role;
                res.word.last_byte   = (c_sleft <= 32'd1);
                if (c_sleft != 32'd0) begin
                    n_sleft = sleft_dec;
                end
                if (n_sleft == 32'd0) begin
                    do_sdone = 1'b1;
                end
            end
            PH_SZ0: begin
                case (b[7:6])
                    2'b00: begin
                        do_fin = 1'b1;
                        fin_v  = {58'd0, b[5:0]};
                    end
                    2'b01: begin
                        n_acc   = {58'd0, b[5:0]};
                        n_pos   = 4'd1;
                        n_phase = PH_SZC;
                    end
                    2'b10: begin
                        n_acc   = 64'd0;
                        n_pos   = 4'd4;
                        n_phase = PH_SZC;
                    end
                    default: begin
                        if (r_pur == PUR_STRLEN && b <= ENC_INT_MAX) begin
                            n_acc   = 64'd0;
                            n_pos   = 4'd0;
                            n_ilen  = b[1:0];
                            n_phase = PH_INT;
                        end else begin
                            res.vld              = 1'b1;
                            res.word.token_kind  = KIND_BAD_ENCODING;
                            res.word.token_value = {56'd0, b};
                            n_phase              = PH_DEAD;
                        end
                    end
                endcase
            end
            PH_SZC: begin
                n_acc = {c_acc[55:0], b};
                if (c_pos != 4'd0) begin
                    n_pos = c_pos - 4'd1;
                end
                if (n_pos == 4'd0) begin
                    do_fin = 1'b1;
                    fin_v  = n_acc;
                end
            end
            PH_INT: begin
                for (int i = 0; i < 4; i++) begin
                    if (c_pos[1:0] == 2'(i)) begin
                        n_acc[8*i +: 8] = c_acc[8*i +: 8] | b;
                    end
                end
                n_pos = {1'b0, ipos_inc};
                if (ipos_inc >= ineed) begin
                    case (r_ilen)
                        2'd0:    ival = {{56{n_acc[7]}}, n_acc[7:0]};
                        2'd1:    ival = {{48{n_acc[15]}}, n_acc[15:0]};
                        default: ival = {{32{n_acc[31]}}, n_acc[31:0]};
                    endcase
                    res.vld              = 1'b1;
                    res.word.token_kind  = KIND_INT_STRING;
                    res.word.token_value = ival;
                    res.word.string_role = c_role;
                    do_sdone             = 1'b1;
                end
            end
            default: begin
                n_phase = PH_DEAD;
            end
        endcase

        if (do_vtype) begin
            if (b == TYPE_STRING) begin
                n_role  = 2'd2;
                n_pur   = PUR_STRLEN;
                n_phase = PH_SZ0;
            end else begin
                res.vld              = 1'b1;
                res.word.token_kind  = KIND_BAD_TYPE;
                res.word.token_value = {56'd0, b};
                n_phase              = PH_DEAD;
            end
        end

        if (do_fin) begin
            res.vld              = 1'b1;
            res.word.token_value = fin_v;
            case (r_pur)
                PUR_DB: begin
                    res.word.token_kind = KIND_DB_INDEX;
                    n_phase             = PH_TOP;
                end
                PUR_TSIZE: begin
                    res.word.token_kind = KIND_TABLE_SIZE;
                    n_eleft = (fin_v[63:COUNT_WIDTH] != '0) ? COUNT_CAP
                                                            : fin_v[COUNT_WIDTH-1:0];
                    n_pur               = PUR_ESIZE;
                    n_phase             = PH_SZ0;
                end
                PUR_ESIZE: begin
                    res.word.token_kind = KIND_EXPIRY_SIZE;
                    n_phase             = PH_TOP;
                end
                default: begin
                    res.word.token_kind  = KIND_STR_LEN;
                    res.word.string_role = c_role;
                    n_sleft              = fin_v[31:0];
                    if (fin_v[31:0] == 32'd0) begin
                        do_sdone = 1'b1;
                    end else begin
                        n_phase = PH_STRB;
                    end
                end
            endcase
        end

        if (do_sdone) begin
            case (c_role)
                2'd0: begin
                    n_role  = 2'd1;
                    n_pur   = PUR_STRLEN;
                    n_phase = PH_SZ0;
                end
                2'd2: begin
                    n_role  = 2'd3;
                    n_pur   = PUR_STRLEN;
                    n_phase = PH_SZ0;
                end
                default: begin
                    n_phase = PH_TOP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_pos   <= 4'd0;
            r_match <= 1'b1;
            r_acc   <= 64'd0;
            r_sleft <= 32'd0;
            r_eleft <= '0;
            r_role  <= 2'd0;
            r_secs  <= 1'b0;
            r_pur   <= PUR_DB;
            r_ilen  <= 2'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_match <= n_match;
            r_acc   <= n_acc;
            r_sleft <= n_sleft;
            r_eleft <= n_eleft;
            r_role  <= n_role;
            r_secs  <= n_secs;
            r_pur   <= n_pur;
            r_ilen  <= n_ilen;
        end
    end

    assign o_result = res;

endmodule

@@ rtl/core/kvst_out_reg.sv @@
// Result register: holds one token until the consumer takes it.
module kvst_out_reg import kvst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_result   i_result,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_vld;
    logic      n_vld;
    t_out_word r_word;
    logic      load;

    assign load = i_advance & i_result.vld;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (load) begin
            r_word <= i_result.word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

@@ rtl/core/keyvalue_snapshot_tokenizer.sv @@
// Top level of the snapshot tokenizer: input register, parser, result register.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------
//  in      | sink      | i_in_valid / o_in_stall   | t_in_word
//  out     | source    | o_out_valid / i_out_stall | t_out_word
//
// One byte per cycle, sustained while the output is not stalled.
// Each byte passes the input register, is decoded combinationally by the parser,
// and its token (if any) lands in the result register.
// Reset is synchronous, active low, and returns the parser to the header.
// A stall on the output holds the result register; input stalls only when
// both registers are full and the output is stalled.
module keyvalue_snapshot_tokenizer import kvst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    t_in_stage in_stage;
    t_result   result;
    logic      advance;

    assign advance = in_stage.vld & (~o_out_valid | ~i_out_stall);

    kvst_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_word    (i_in_word),
        .o_stall   (o_in_stall),
        .i_advance (advance),
        .o_stage   (in_stage)
    );

    kvst_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (in_stage.word),
        .o_result  (result)
    );

    kvst_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_result  (result),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_word    (o_out_word)
    );

endmodule

@@ rtl/core/kvst_checker.sv @@
// Port-level checks on the snapshot tokenizer, bound to the top level.
module kvst_checker import kvst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_word o_out_word,
    input logic      i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled output");

    a_last_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last_byte |-> o_out_word.token_kind == KIND_STR_BYTE)
        else $error("last byte flag on a non-byte token");

    a_role_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.string_role != 2'd0 |->
            o_out_word.token_kind == KIND_STR_LEN ||
            o_out_word.token_kind == KIND_STR_BYTE ||
            o_out_word.token_kind == KIND_INT_STRING)
        else $error("string role on a non-string token");

    a_header_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.token_kind == KIND_HEADER_OK ||
            o_out_word.token_kind == KIND_HEADER_BAD ||
            o_out_word.token_kind == KIND_END) |-> o_out_word.token_value == 64'd0)
        else $error("header or end token with a nonzero value");

endmodule

bind keyvalue_snapshot_tokenizer kvst_checker u_kvst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
